// ===== rtl/bis_pkg.sv =====
package bis_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned TGT_SIZE_W = 13;
  localparam int unsigned SRC_REG_W  = 9;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TGT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TGT_HEIGHT = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic               action;
    logic [7:0]         load_x;
    logic [7:0]         load_y;
    logic [7:0]         load_red;
    logic [7:0]         load_green;
    logic [7:0]         load_blue;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } st_ctl_t;

endpackage

// ===== rtl/bis_stream_if.sv =====
interface bis_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bilinear_rgb_image_scaler_unit.sv =====
// Throughput: one word per cycle, load or compute, while compute words find free
//   result slots; set by the bit-per-stage divider pipelines of NUM_W = 13 +
//   clog2(max source dimension + 1) + FRACTION_BITS bits (30 at the defaults)
//   and one read per cycle on each of four parity banks.
// Reset: size registers return to 256 and all valid and credit state clears;
//   the pixel store is not cleared and holds nothing meaningful until loaded.
module bilinear_rgb_image_scaler_unit #(
  parameter int unsigned MAX_SOURCE_WIDTH  = 256,
  parameter int unsigned MAX_SOURCE_HEIGHT = 256,
  parameter int unsigned FRACTION_BITS     = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bis_stream_if.sink         in_i,
  bis_stream_if.source       out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SW_W    = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int unsigned SH_W    = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int unsigned X_W     = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned Y_W     = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned SMAX_W  = (SW_W > SH_W) ? SW_W : SH_W;
  localparam int unsigned NUM_W   = bis_pkg::TGT_SIZE_W + SMAX_W + FRACTION_BITS;
  localparam int unsigned AX_LAT  = NUM_W + 3;
  localparam int unsigned PIPE_LAT = AX_LAT + 3;
  localparam int unsigned OUT_DEPTH = PIPE_LAT + 4;
  localparam int unsigned CR_W    = $clog2(OUT_DEPTH + 1);
  localparam int unsigned TW      = bis_pkg::TGT_SIZE_W;
  localparam int unsigned RW      = bis_pkg::SRC_REG_W;

  typedef struct packed {
    logic          is_load;
    logic [7:0]    x;
    logic [7:0]    y;
    bis_pkg::rgb_t pix;
  } pay_t;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [RW-1:0] src_w_q, src_h_q;
  logic [TW-1:0] tgt_w_q, tgt_h_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RW'(256);
      src_h_q <= RW'(256);
      tgt_w_q <= TW'(256);
      tgt_h_q <= TW'(256);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bis_pkg::REG_SRC_WIDTH:  src_w_q <= pwdata[RW-1:0];
        bis_pkg::REG_SRC_HEIGHT: src_h_q <= pwdata[RW-1:0];
        bis_pkg::REG_TGT_WIDTH:  tgt_w_q <= pwdata[TW-1:0];
        default:                 tgt_h_q <= pwdata[TW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bis_pkg::REG_SRC_WIDTH:  prdata = 32'(src_w_q);
      bis_pkg::REG_SRC_HEIGHT: prdata = 32'(src_h_q);
      bis_pkg::REG_TGT_WIDTH:  prdata = 32'(tgt_w_q);
      default:                 prdata = 32'(tgt_h_q);
    endcase
  end

  // Effective sizes: zero acts as one, source sizes saturate at the store size
  logic [SW_W-1:0] src_w;
  logic [SH_W-1:0] src_h;
  logic [TW-1:0]   tgt_w, tgt_h;

  always_comb begin
    if (src_w_q == '0) begin
      src_w = SW_W'(1);
    end else if (16'(src_w_q) > 16'(MAX_SOURCE_WIDTH)) begin
      src_w = SW_W'(MAX_SOURCE_WIDTH);
    end else begin
      src_w = SW_W'(src_w_q);
    end
    if (src_h_q == '0) begin
      src_h = SH_W'(1);
    end else if (16'(src_h_q) > 16'(MAX_SOURCE_HEIGHT)) begin
      src_h = SH_W'(MAX_SOURCE_HEIGHT);
    end else begin
      src_h = SH_W'(src_h_q);
    end
    tgt_w = (tgt_w_q == '0) ? TW'(1) : tgt_w_q;
    tgt_h = (tgt_h_q == '0) ? TW'(1) : tgt_h_q;
  end

  // ------------------------------------------------------------------
  // Front: input queue, classify load or compute, issue into the back
  // ------------------------------------------------------------------
  logic              in_full, head_vld, head_is_compute, credit_ok, issue;
  bis_pkg::in_item_t head;
  logic [CR_W-1:0]   cr_q, cr_d;
  logic              out_vld, out_full, deliver;

  bis_fifo #(
    .DEPTH (2),
    .T     (bis_pkg::in_item_t)
  ) u_front_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid && in_i.ready),
    .data_i  (in_i.data),
    .full_o  (in_full),
    .pop_i   (issue),
    .valid_o (head_vld),
    .data_o  (head)
  );

  assign in_i.ready = !in_full;

  // A compute word needs a slot in the result queue before it may enter;
  // loads never produce a result and pass freely.
  assign head_is_compute = (head.action == bis_pkg::ACT_COMPUTE);
  assign credit_ok       = (cr_q < CR_W'(OUT_DEPTH));
  assign issue           = head_vld && (!head_is_compute || credit_ok);
  assign deliver         = out_vld && out_o.ready;

  always_comb begin
    cr_d = cr_q + CR_W'(issue && head_is_compute) - CR_W'(deliver);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q <= '0;
    end else begin
      cr_q <= cr_d;
    end
  end

  // ------------------------------------------------------------------
  // Back: coordinate mapping, delayed alongside the word's own payload
  // ------------------------------------------------------------------
  logic [AX_LAT-1:0] vld_q;
  pay_t              pay_q [AX_LAT];
  pay_t              pay_in;

  assign pay_in = '{is_load: !head_is_compute, x: head.load_x, y: head.load_y,
                    pix: '{red: head.load_red, green: head.load_green,
                           blue: head.load_blue}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[AX_LAT-2:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q[0] <= pay_in;
    for (int i = 1; i < AX_LAT; i++) begin
      pay_q[i] <= pay_q[i-1];
    end
  end

  logic [X_W-1:0]           x0, x1;
  logic [Y_W-1:0]           y0, y1;
  logic [FRACTION_BITS-1:0] fx, fy;

  bis_axis_map #(
    .SRC_W  (SW_W),
    .IP_W   (X_W),
    .FRAC_W (FRACTION_BITS),
    .NUM_W  (NUM_W)
  ) u_map_x (
    .clk_i   (clk_i),
    .coord_i (head.target_x),
    .src_i   (src_w),
    .dst_i   (tgt_w),
    .ip0_o   (x0),
    .ip1_o   (x1),
    .frac_o  (fx)
  );

  bis_axis_map #(
    .SRC_W  (SH_W),
    .IP_W   (Y_W),
    .FRAC_W (FRACTION_BITS),
    .NUM_W  (NUM_W)
  ) u_map_y (
    .clk_i   (clk_i),
    .coord_i (head.target_y),
    .src_i   (src_h),
    .dst_i   (tgt_h),
    .ip0_o   (y0),
    .ip1_o   (y1),
    .frac_o  (fy)
  );

  // Loads write at the same point where computes read, keeping order.
  // Drop loads whose coordinate falls outside the store.
  pay_t             pay_end;
  bis_pkg::st_ctl_t st_ctl;
  logic             load_in_range;

  assign pay_end       = pay_q[AX_LAT-1];
  assign load_in_range = (16'(pay_end.x) < 16'(MAX_SOURCE_WIDTH)) &&
                         (16'(pay_end.y) < 16'(MAX_SOURCE_HEIGHT));
  assign st_ctl.wr_en  = vld_q[AX_LAT-1] && pay_end.is_load && load_in_range;
  assign st_ctl.rd_en  = vld_q[AX_LAT-1] && !pay_end.is_load;

  logic                     st_vld;
  bis_pkg::rgb_t            pa, pb, pc, pd;
  logic [FRACTION_BITS-1:0] st_fx, st_fy;

  bis_pixel_store #(
    .X_W    (X_W),
    .Y_W    (Y_W),
    .FRAC_W (FRACTION_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (st_ctl),
    .wr_x_i   (X_W'(pay_end.x)),
    .wr_y_i   (Y_W'(pay_end.y)),
    .wr_pix_i (pay_end.pix),
    .x0_i     (x0),
    .x1_i     (x1),
    .y0_i     (y0),
    .y1_i     (y1),
    .fx_i     (fx),
    .fy_i     (fy),
    .vld_o    (st_vld),
    .pa_o     (pa),
    .pb_o     (pb),
    .pc_o     (pc),
    .pd_o     (pd),
    .fx_o     (st_fx),
    .fy_o     (st_fy)
  );

  logic          bl_vld;
  bis_pkg::rgb_t bl_pix;

  bis_blend #(
    .FRAC_W (FRACTION_BITS)
  ) u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (st_vld),
    .pa_i   (pa),
    .pb_i   (pb),
    .pc_i   (pc),
    .pd_i   (pd),
    .fx_i   (st_fx),
    .fy_i   (st_fy),
    .vld_o  (bl_vld),
    .pix_o  (bl_pix)
  );

  // ------------------------------------------------------------------
  // Result queue: holds every credited word, so the back never stalls
  // ------------------------------------------------------------------
  bis_pkg::out_item_t res_word;

  assign res_word = '{out_red: bl_pix.red, out_green: bl_pix.green,
                      out_blue: bl_pix.blue};

  bis_fifo #(
    .DEPTH (OUT_DEPTH),
    .T     (bis_pkg::out_item_t)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bl_vld),
    .data_i  (res_word),
    .full_o  (out_full),
    .pop_i   (deliver),
    .valid_o (out_vld),
    .data_o  (out_o.data)
  );

  assign out_o.valid = out_vld;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_vld |-> !out_full)
    else $error("result pushed into a full queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q <= CR_W'(OUT_DEPTH))
    else $error("credit count above queue depth");

  a_result_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld |-> (cr_q != '0))
    else $error("result shown with no compute word outstanding");

  a_no_issue_without_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && head_is_compute) |-> credit_ok)
    else $error("compute word issued without a free result slot");
`endif

endmodule

// ===== rtl/bis_fifo.sv =====
module bis_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output T     data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  T               data_q;
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           vld_q, vld_d;
  logic           push_ok, load;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign push_ok = push_i && !full_o;
  // prefetch the head word into the output register
  assign load    = (cnt_q != '0) && (!vld_q || pop_i);

  always_comb begin
    wr_ptr_d = push_ok ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = load ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_ok) - CW'(load);
    vld_d    = load ? 1'b1 : (pop_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= data_i;
    end
    if (load) begin
      data_q <= mem[rd_ptr_q];
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bis_axis_map.sv =====
module bis_axis_map #(
  parameter int unsigned SRC_W  = 9,
  parameter int unsigned IP_W   = 8,
  parameter int unsigned FRAC_W = 8,
  parameter int unsigned NUM_W  = 30
) (
  input  logic                          clk_i,
  input  logic [bis_pkg::COORD_W-1:0]   coord_i,
  input  logic [SRC_W-1:0]              src_i,
  input  logic [bis_pkg::TGT_SIZE_W-1:0] dst_i,
  output logic [IP_W-1:0]               ip0_o,
  output logic [IP_W-1:0]               ip1_o,
  output logic [FRAC_W-1:0]             frac_o
);

  localparam int unsigned UP_W  = bis_pkg::TGT_SIZE_W + SRC_W;
  localparam int unsigned DIV_W = bis_pkg::TGT_SIZE_W + 1;

  logic [UP_W-1:0]  up_q;
  logic [DIV_W-1:0] div;
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DIV_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W+1];
  logic [IP_W-1:0]  ip0_q, ip1_q, ip0_d, ip1_d;
  logic [FRAC_W-1:0] frac_q;
  logic [NUM_W-1:0] ipf;
  logic [SRC_W-1:0] lim;

  assign div = {dst_i, 1'b0};

  // scaled position numerator (2d+1)*src
  always_ff @(posedge clk_i) begin
    up_q <= UP_W'({coord_i, 1'b1}) * UP_W'(src_i);
  end

  // drop to zero when the centre falls left of the first pixel
  always_ff @(posedge clk_i) begin
    num_q[0] <= (up_q <= UP_W'(dst_i)) ? '0 : (NUM_W'(up_q - UP_W'(dst_i)) << FRAC_W);
    rem_q[0] <= '0;
    quo_q[0] <= '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [DIV_W:0] trial;
    logic           ge;
    assign trial = {rem_q[k], num_q[k][NUM_W-1]};
    assign ge    = (trial >= {1'b0, div});
    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][NUM_W-2:0], ge};
    end
    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? DIV_W'(trial - {1'b0, div}) : DIV_W'(trial);
        num_q[k+1] <= num_q[k] << 1;
      end
    end
  end

  always_comb begin
    lim   = src_i - 1'b1;
    ipf   = quo_q[NUM_W] >> FRAC_W;
    ip0_d = (ipf > NUM_W'(lim)) ? IP_W'(lim) : IP_W'(ipf);
    ip1_d = (ip0_d >= IP_W'(lim)) ? ip0_d : ip0_d + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    ip0_q  <= ip0_d;
    ip1_q  <= ip1_d;
    frac_q <= quo_q[NUM_W][FRAC_W-1:0];
  end

  assign ip0_o  = ip0_q;
  assign ip1_o  = ip1_q;
  assign frac_o = frac_q;

endmodule

// ===== rtl/bis_pixel_store.sv =====
module bis_pixel_store #(
  parameter int unsigned X_W    = 8,
  parameter int unsigned Y_W    = 8,
  parameter int unsigned FRAC_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bis_pkg::st_ctl_t  ctl_i,
  input  logic [X_W-1:0]    wr_x_i,
  input  logic [Y_W-1:0]    wr_y_i,
  input  bis_pkg::rgb_t     wr_pix_i,
  input  logic [X_W-1:0]    x0_i,
  input  logic [X_W-1:0]    x1_i,
  input  logic [Y_W-1:0]    y0_i,
  input  logic [Y_W-1:0]    y1_i,
  input  logic [FRAC_W-1:0] fx_i,
  input  logic [FRAC_W-1:0] fy_i,
  output logic              vld_o,
  output bis_pkg::rgb_t     pa_o,
  output bis_pkg::rgb_t     pb_o,
  output bis_pkg::rgb_t     pc_o,
  output bis_pkg::rgb_t     pd_o,
  output logic [FRAC_W-1:0] fx_o,
  output logic [FRAC_W-1:0] fy_o
);

  localparam int unsigned XH_W  = (X_W > 1) ? X_W - 1 : 1;
  localparam int unsigned YH_W  = (Y_W > 1) ? Y_W - 1 : 1;
  localparam int unsigned A_W   = XH_W + YH_W;
  localparam int unsigned DEPTH = 1 << A_W;

  bis_pkg::rgb_t bank_q [4];
  logic          x0p_q, x1p_q, y0p_q, y1p_q, vld_q;
  logic [FRAC_W-1:0] fx_q, fy_q;

  function automatic bis_pkg::rgb_t pick(input logic [1:0] s, input bis_pkg::rgb_t b0,
                                         input bis_pkg::rgb_t b1, input bis_pkg::rgb_t b2,
                                         input bis_pkg::rgb_t b3);
    bis_pkg::rgb_t r;
    unique case (s)
      2'd0:    r = b0;
      2'd1:    r = b1;
      2'd2:    r = b2;
      default: r = b3;
    endcase
    return r;
  endfunction

  // four banks split by column and row parity, so the four neighbours land in
  // distinct banks, but at a clamped edge two of them coincide and share a bank
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PX = 1'((b >> 0) & 1);
    localparam logic PY = 1'((b >> 1) & 1);
    bis_pkg::rgb_t  mem [DEPTH];
    logic [X_W-1:0] rx;
    logic [Y_W-1:0] ry;
    logic [A_W-1:0] rd_addr, wr_addr;
    logic           wr_hit;

    assign rx      = (x0_i[0] == PX) ? x0_i : x1_i;
    assign ry      = (y0_i[0] == PY) ? y0_i : y1_i;
    assign rd_addr = {YH_W'(ry >> 1), XH_W'(rx >> 1)};
    assign wr_addr = {YH_W'(wr_y_i >> 1), XH_W'(wr_x_i >> 1)};
    assign wr_hit  = ctl_i.wr_en && (wr_x_i[0] == PX) && (wr_y_i[0] == PY);

    always_ff @(posedge clk_i) begin
      if (wr_hit) begin
        mem[wr_addr] <= wr_pix_i;
      end
      if (ctl_i.rd_en) begin
        bank_q[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x0p_q <= x0_i[0];
    x1p_q <= x1_i[0];
    y0p_q <= y0_i[0];
    y1p_q <= y1_i[0];
    fx_q  <= fx_i;
    fy_q  <= fy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.rd_en;
    end
  end

  assign pa_o  = pick({y0p_q, x0p_q}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
  assign pb_o  = pick({y0p_q, x1p_q}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
  assign pc_o  = pick({y1p_q, x0p_q}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
  assign pd_o  = pick({y1p_q, x1p_q}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
  assign vld_o = vld_q;
  assign fx_o  = fx_q;
  assign fy_o  = fy_q;

endmodule

// ===== rtl/bis_blend.sv =====
module bis_blend #(
  parameter int unsigned FRAC_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  bis_pkg::rgb_t     pa_i,
  input  bis_pkg::rgb_t     pb_i,
  input  bis_pkg::rgb_t     pc_i,
  input  bis_pkg::rgb_t     pd_i,
  input  logic [FRAC_W-1:0] fx_i,
  input  logic [FRAC_W-1:0] fy_i,
  output logic              vld_o,
  output bis_pkg::rgb_t     pix_o
);

  localparam int unsigned H_W = FRAC_W + 8;

  logic [H_W-1:0]    h0_q [3];
  logic [H_W-1:0]    h1_q [3];
  logic [FRAC_W-1:0] fy_q;
  logic [23:0]       res_q;
  logic              vld1_q, vld2_q;

  // per channel: a + (b - a) * f, once across and once down
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [7:0]                a, b, cc, d;
    logic signed [8:0]         dif0, dif1;
    logic signed [FRAC_W:0]    fxs, fys;
    logic signed [FRAC_W+9:0]  m0, m1, s0, s1;
    logic signed [H_W:0]       dv;
    logic signed [2*FRAC_W+9:0] mv, sv;

    assign a    = pa_i[8*c +: 8];
    assign b    = pb_i[8*c +: 8];
    assign cc   = pc_i[8*c +: 8];
    assign d    = pd_i[8*c +: 8];
    assign fxs  = $signed({1'b0, fx_i});
    assign dif0 = $signed({1'b0, b}) - $signed({1'b0, a});
    assign dif1 = $signed({1'b0, d}) - $signed({1'b0, cc});
    assign m0   = dif0 * fxs;
    assign m1   = dif1 * fxs;
    assign s0   = $signed({2'b00, a, {FRAC_W{1'b0}}}) + m0;
    assign s1   = $signed({2'b00, cc, {FRAC_W{1'b0}}}) + m1;

    always_ff @(posedge clk_i) begin
      h0_q[c] <= s0[H_W-1:0];
      h1_q[c] <= s1[H_W-1:0];
    end

    assign fys = $signed({1'b0, fy_q});
    assign dv  = $signed({1'b0, h1_q[c]}) - $signed({1'b0, h0_q[c]});
    assign mv  = dv * fys;
    assign sv  = $signed({2'b00, h0_q[c], {FRAC_W{1'b0}}}) + mv;

    always_ff @(posedge clk_i) begin
      res_q[8*c +: 8] <= sv[2*FRAC_W +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    fy_q <= fy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign vld_o = vld2_q;
  assign pix_o = bis_pkg::rgb_t'(res_q);

endmodule
